[hdl/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, constants and helpers of the gyro bias calibration sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

	localparam int GYRO_W      = 16;
	localparam int OUT_W       = GYRO_W + 1;
	localparam int TEMP_W      = 12;
	localparam int WIN_W       = 8;
	localparam int SETTLE_W    = 11;
	localparam int SCHK_W      = 10;
	localparam int PERIOD_W    = 4;
	localparam int CNT_W       = 13;
	localparam int ACC_W       = 29;
	localparam int MAG_W       = ACC_W - 1;
	localparam int DIV_STEPS   = MAG_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int MAX_CAL_SAMPLES = 4096;
	localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

	localparam logic [1:0] PH_WARMUP = 2'd0;
	localparam logic [1:0] PH_CAL    = 2'd1;
	localparam logic [1:0] PH_RUN    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_CHECKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_QUICK_START   = 3'd5;

	typedef struct packed {
		logic             accept;
		logic             acc_add;
		logic             acc_clear;
		logic             div_start;
		logic             subtract;
		logic [1:0]       phase;
		logic [CNT_W-1:0] divisor;
	} gbc_cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
	} gbc_stat_t;

	// effective sample count: zero means one, clamped to the maximum
	function automatic logic [CNT_W-1:0] eff_samples(input logic [CNT_W-1:0] cal);
		logic [CNT_W-1:0] res;
		res = cal;
		if (cal == '0)
			res = CNT_W'(1);
		else if (cal > CNT_W'(MAX_CAL_SAMPLES))
			res = CNT_W'(MAX_CAL_SAMPLES);
		return res;
	endfunction

endpackage

`default_nettype wire

[hdl/gbc_if.sv]
// ----------------------------------------------------------------------------
// gbc_if
// Valid/ready channels for IMU samples and calibrated rate results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbc_sample_if import gbc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [GYRO_W-1:0] gyro_x;
	logic signed [GYRO_W-1:0] gyro_y;
	logic signed [GYRO_W-1:0] gyro_z;
	logic signed [TEMP_W-1:0] temperature;

	modport source (output valid, gyro_x, gyro_y, gyro_z, temperature, input ready);
	modport sink (input valid, gyro_x, gyro_y, gyro_z, temperature, output ready);
endinterface

interface gbc_result_if import gbc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] rate_x;
	logic signed [OUT_W-1:0] rate_y;
	logic signed [OUT_W-1:0] rate_z;
	logic [1:0]              phase;

	modport source (output valid, rate_x, rate_y, rate_z, phase, input ready);
	modport sink (input valid, rate_x, rate_y, rate_z, phase, output ready);
endinterface

`default_nettype wire

[hdl/gbc_dpath.sv]
// ----------------------------------------------------------------------------
// gbc_dpath
// Bias accumulators, shared-step bias divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_dpath import gbc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire gbc_cmd_t                 cmd,
	output gbc_stat_t                     stat,
	input  wire logic signed [GYRO_W-1:0] gyro_x,
	input  wire logic signed [GYRO_W-1:0] gyro_y,
	input  wire logic signed [GYRO_W-1:0] gyro_z,
	gbc_result_if.source                  result
);

	logic signed [ACC_W-1:0] accum_q [3];
	logic signed [ACC_W-1:0] acc_sum [3];
	logic [GYRO_W-1:0]       gyro [3];
	logic [MAG_W-1:0]        dvd_q [3];
	logic [CNT_W-1:0]        rem_q [3];
	logic                    neg_q [3];
	logic [MAG_W-1:0]        dvd_nx [3];
	logic [CNT_W-1:0]        rem_nx [3];
	logic [CNT_W-1:0]        divisor_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        rate_q [3];
	logic [1:0]              phase_q;

	assign gyro[0] = gyro_x;
	assign gyro[1] = gyro_y;
	assign gyro[2] = gyro_z;

	assign stat.out_free = !out_valid_q || result.ready;
	assign stat.div_done = busy_q && (step_q == STEP_W'(1));

	// running sums including the current sample
	always_comb begin
		for (int i = 0; i < 3; i++)
			acc_sum[i] = accum_q[i] + {{(ACC_W-GYRO_W){gyro[i][GYRO_W-1]}}, gyro[i]};
	end

	// one restoring division step per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [CNT_W:0]   part;
			logic [CNT_W+1:0] diff;
			part = {rem_q[i], dvd_q[i][MAG_W-1]};
			diff = {1'b0, part} - {2'b00, divisor_q};
			if (!diff[CNT_W+1]) begin
				rem_nx[i] = diff[CNT_W-1:0];
				dvd_nx[i] = {dvd_q[i][MAG_W-2:0], 1'b1};
			end else begin
				rem_nx[i] = part[CNT_W-1:0];
				dvd_nx[i] = {dvd_q[i][MAG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				accum_q[i] <= '0;
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (cmd.acc_clear) begin
				for (int i = 0; i < 3; i++)
					accum_q[i] <= '0;
			end else if (cmd.acc_add) begin
				for (int i = 0; i < 3; i++)
					accum_q[i] <= acc_sum[i];
			end else if (busy_q && step_q == STEP_W'(1)) begin
				for (int i = 0; i < 3; i++)
					accum_q[i] <= neg_q[i] ? -$signed({1'b0, dvd_nx[i]})
						: $signed({1'b0, dvd_nx[i]});
			end
			if (cmd.div_start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// divider lanes, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= cmd.divisor;
			for (int i = 0; i < 3; i++) begin
				logic [ACC_W-1:0] src;
				logic [ACC_W-1:0] mag;
				src = cmd.acc_add ? acc_sum[i] : accum_q[i];
				mag = src[ACC_W-1] ? ACC_W'(-src) : src;
				neg_q[i] <= src[ACC_W-1];
				dvd_q[i] <= mag[MAG_W-1:0];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				dvd_q[i] <= dvd_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.accept)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			phase_q <= cmd.phase;
			for (int i = 0; i < 3; i++) begin
				logic [OUT_W-1:0] g_ext;
				g_ext = {gyro[i][GYRO_W-1], gyro[i]};
				rate_q[i] <= cmd.subtract ? g_ext - accum_q[i][OUT_W-1:0] : g_ext;
			end
		end
	end

	assign result.valid  = out_valid_q;
	assign result.rate_x = rate_q[0];
	assign result.rate_y = rate_q[1];
	assign result.rate_z = rate_q[2];
	assign result.phase  = phase_q;

endmodule

`default_nettype wire

[hdl/gbc_ctrl.sv]
// ----------------------------------------------------------------------------
// gbc_ctrl
// Configuration registers, phase sequencing and warm-up temperature checks.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_ctrl import gbc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                     in_valid,
	input  wire logic signed [TEMP_W-1:0] temperature,
	output logic                          in_ready,
	output gbc_cmd_t                      cmd,
	input  wire gbc_stat_t                stat
);

	typedef enum logic [1:0] {
		ST_ACTIVE = 2'b01,
		ST_DIVIDE = 2'b10
	} state_t;

	state_t                    state_q, state_nx;
	logic signed [TEMP_W-1:0]  target_temp_q;
	logic [WIN_W-1:0]          temp_window_q;
	logic [SCHK_W-1:0]         settle_checks_q;
	logic [PERIOD_W-1:0]       check_period_q;
	logic [CNT_W-1:0]          cal_samples_q;
	logic                      quick_start_q;

	logic [1:0]                phase_q, phase_nx;
	logic [PERIOD_W-1:0]       tick_q, tick_nx;
	logic [SETTLE_W-1:0]       settle_q, settle_nx;
	logic [CNT_W-1:0]          count_q, count_nx;

	logic [PERIOD_W-1:0]       period;
	logic signed [TEMP_W:0]    err;
	logic [TEMP_W:0]           err_abs;
	logic                      in_window;
	logic                      accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp_q   <= TEMP_W'(320);
			temp_window_q   <= WIN_W'(4);
			settle_checks_q <= SCHK_W'(300);
			check_period_q  <= PERIOD_W'(10);
			cal_samples_q   <= CNT_W'(1000);
			quick_start_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_TEMP:   target_temp_q   <= cfg_wdata[TEMP_W-1:0];
				CFG_TEMP_WINDOW:   temp_window_q   <= cfg_wdata[WIN_W-1:0];
				CFG_SETTLE_CHECKS: settle_checks_q <= cfg_wdata[SCHK_W-1:0];
				CFG_CHECK_PERIOD:  check_period_q  <= cfg_wdata[PERIOD_W-1:0];
				CFG_CAL_SAMPLES:   cal_samples_q   <= cfg_wdata[CNT_W-1:0];
				CFG_QUICK_START:   quick_start_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_ACTIVE) && stat.out_free;
	assign accept    = in_valid && in_ready;
	assign period    = (check_period_q == '0) ? PERIOD_W'(1) : check_period_q;
	assign err       = {temperature[TEMP_W-1], temperature}
		- {target_temp_q[TEMP_W-1], target_temp_q};
	assign err_abs   = err[TEMP_W] ? (TEMP_W+1)'(1) + ~err : err;
	assign in_window = quick_start_q
		|| (err_abs < {{(TEMP_W+1-WIN_W){1'b0}}, temp_window_q});

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.phase     = phase_q;
		cmd.subtract  = (phase_q == PH_RUN);
		cmd.divisor   = eff_samples(cal_samples_q);
		state_nx      = state_q;
		phase_nx      = phase_q;
		tick_nx       = tick_q;
		settle_nx     = settle_q;
		count_nx      = count_q;
		case (state_q)
			ST_ACTIVE: begin
				if (accept) begin
					if (phase_q == PH_CAL) begin
						if (quick_start_q) begin
							cmd.acc_clear = 1'b1;
							phase_nx      = PH_RUN;
						end else begin
							cmd.acc_add = 1'b1;
							count_nx    = count_q + CNT_W'(1);
							if (count_nx >= cmd.divisor) begin
								cmd.div_start = 1'b1;
								phase_nx      = PH_RUN;
								state_nx      = ST_DIVIDE;
							end
						end
					end
					if (tick_q == '0 && phase_q == PH_WARMUP && in_window) begin
						if (settle_q != SETTLE_MAX)
							settle_nx = settle_q + SETTLE_W'(1);
						if (settle_nx > {1'b0, settle_checks_q})
							phase_nx = PH_CAL;
					end
					if ({1'b0, tick_q} + (PERIOD_W+1)'(1) >= {1'b0, period})
						tick_nx = '0;
					else
						tick_nx = tick_q + PERIOD_W'(1);
				end
			end
			ST_DIVIDE: begin
				if (stat.div_done)
					state_nx = ST_ACTIVE;
			end
			default: state_nx = ST_ACTIVE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_ACTIVE;
			phase_q  <= PH_WARMUP;
			tick_q   <= '0;
			settle_q <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_nx;
			phase_q  <= phase_nx;
			tick_q   <= tick_nx;
			settle_q <= settle_nx;
			count_q  <= count_nx;
		end
	end

	a_no_accept_divide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> !in_ready)
		else $error("transaction accepted during bias division");

	a_div_enters_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == ST_DIVIDE && phase_q == PH_RUN)
		else $error("division start without run phase");

	a_count_only_cal: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && phase_q == PH_CAL) |=> $stable(count_q))
		else $error("sample count moved outside calibration");

	a_settle_only_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_WARMUP |=> $stable(settle_q))
		else $error("settle count moved outside warm-up");

endmodule

`default_nettype wire

[hdl/gyro_bias_calibration_sequencer_top.sv]
// ----------------------------------------------------------------------------
// gyro_bias_calibration_sequencer_top
// Gyro zero-rate bias calibration: warm-up, calibration and run phases.
// ----------------------------------------------------------------------------
// usage:
//   sample: one IMU transaction per tick (three gyro axes, temperature)
//   result: one transaction per sample with the rates and the phase in use
//   cfg_we/cfg_index/cfg_wdata: register writes, only while the block is idle
// timing: the result is registered and appears in the cycle after its sample is accepted
// throughput: one sample per cycle while the result path is free; the sample that
//   completes calibration is followed by a pause while the shared-step divider
//   turns the three sums into biases, one quotient bit per axis per cycle
// reset: phase returns to warm-up, counters and sums clear, registers take
//   their defaults (40 degrees, 0.5 degree window, 300 checks, period 10,
//   1000 samples, quick start off)
// stall: the result register holds while result.ready is low; a new sample
//   is taken in the cycle the held result is taken, none while it waits
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_calibration_sequencer_top import gbc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	gbc_sample_if.sink                 sample,
	gbc_result_if.source               result
);

	gbc_cmd_t  cmd;
	gbc_stat_t stat;
	logic      in_ready;

	assign sample.ready = in_ready;

	gbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (sample.valid),
		.temperature (sample.temperature),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	gbc_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.gyro_x (sample.gyro_x),
		.gyro_y (sample.gyro_y),
		.gyro_z (sample.gyro_z),
		.result (result)
	);

endmodule

`default_nettype wire
